FILE: src/utn_pkg.sv
// Shared types and constants of the UTF-8 text normalizer.
// No dependencies; imported by utn_front, utn_queue, utn_back and the top level.
`default_nettype none
package utn_pkg;

   // most output beats one input byte can produce
   localparam int MAX_RES = 5;
   localparam int COUNT_W = $clog2(MAX_RES + 1);
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int CP_W = 21;
   localparam logic [CP_W-1:0] CP_ASCII_MAX = 21'h00007F;
   localparam logic [CP_W-1:0] CP_NBSP      = 21'h0000A0;
   localparam logic [CP_W-1:0] CP_LSQUO     = 21'h002018;
   localparam logic [CP_W-1:0] CP_RSQUO     = 21'h002019;
   localparam logic [CP_W-1:0] CP_SBQUO     = 21'h00201A;
   localparam logic [CP_W-1:0] CP_LDQUO     = 21'h00201C;
   localparam logic [CP_W-1:0] CP_RDQUO     = 21'h00201D;
   localparam logic [CP_W-1:0] CP_ENDASH    = 21'h002013;
   localparam logic [CP_W-1:0] CP_EMDASH    = 21'h002014;
   localparam logic [CP_W-1:0] CP_FW_FIRST  = 21'h00FF01;
   localparam logic [CP_W-1:0] CP_FW_LAST   = 21'h00FF5E;
   localparam logic [7:0]      FW_OFFSET    = 8'h20;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_HYPHEN = 8'h2D;
   localparam logic [7:0] CH_APOS   = 8'h27;

   // one queue entry: all beats caused by one input byte
   typedef struct packed {
      logic [MAX_RES-1:0][7:0] bytes;   // beat order: index 0 first
      logic [COUNT_W-1:0]      count;   // 1..MAX_RES beats
      logic                    present; // 0 for a bare end marker
      logic                    last;    // last beat closes the string
   } entry_type;

endpackage
`default_nettype wire

FILE: src/utn_front.sv
// Front end: sequence gathering, code point decode and mapping.
// Produces one queue entry per input byte that yields beats or ends a string; uses utn_pkg.
`default_nettype none
module utn_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [7:0]         req_tdata,   // [7:0] in_byte
   input  wire logic               req_tlast,   // in_final
   output logic                    push_valid,
   output utn_pkg::entry_type      push_data,
   input  wire logic               push_ready
);
   import utn_pkg::*;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_SPACE,
      KIND_EMIT,
      KIND_QUOTE
   } kind_type;

   localparam int NUM_SLOTS = 9;

   function automatic logic [7:0] lower_ascii(input logic [7:0] c);
      lower_ascii = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
   endfunction

   logic [23:0] seq_bytes_ff, seq_bytes_in;
   logic [2:0]  seq_expected_ff, seq_expected_in;
   logic [1:0]  seq_count_ff, seq_count_in;
   logic        last_space_ff, last_space_in;
   logic        space_pending_ff, space_pending_in;

   logic [23:0] seq_bytes_step;
   logic [2:0]  seq_expected_step;
   logic [1:0]  seq_count_step;

   logic            map_en;
   logic [CP_W-1:0] cp;
   logic [31:0]     raw;
   logic [2:0]      raw_len;

   kind_type        kind;
   logic [3:0][7:0] emit_bytes;
   logic [2:0]      emit_len;

   logic [7:0] b;
   logic       fin;
   logic       accept;

   assign b          = req_tdata;
   assign fin        = req_tlast;
   assign req_tready = push_ready;
   assign accept     = req_tvalid && push_ready;

   // sequence gathering
   always_comb begin
      logic cont, lead2, lead3, lead4, do_start;
      cont  = (b[7:6] == 2'b10);
      lead2 = (b[7:5] == 3'b110);
      lead3 = (b[7:4] == 4'b1110);
      lead4 = (b[7:3] == 5'b11110);
      do_start = (seq_expected_ff == 3'd0) || (seq_expected_ff == 3'd2 && !cont);

      map_en            = 1'b0;
      cp                = '0;
      raw               = '0;
      raw_len           = 3'd0;
      seq_bytes_step    = '0;
      seq_expected_step = 3'd0;
      seq_count_step    = 2'd0;

      if (do_start) begin
         if (lead2 || lead3 || lead4) begin
            seq_expected_step = lead2 ? 3'd2 : (lead3 ? 3'd3 : 3'd4);
            seq_bytes_step    = {16'h0000, b};
            seq_count_step    = 2'd1;
         end else begin
            map_en  = 1'b1;
            cp      = {13'h0000, b};
            raw     = {24'h000000, b};
            raw_len = 3'd1;
         end
      end else if (seq_expected_ff == 3'd2) begin
         map_en  = 1'b1;
         cp      = {10'h000, seq_bytes_ff[4:0], b[5:0]};
         raw     = {16'h0000, seq_bytes_ff[7:0], b};
         raw_len = 3'd2;
      end else if (({1'b0, seq_count_ff} + 3'd1) < seq_expected_ff) begin
         seq_expected_step = seq_expected_ff;
         seq_bytes_step    = {seq_bytes_ff[15:0], b};
         seq_count_step    = seq_count_ff + 2'd1;
      end else if (seq_expected_ff == 3'd3) begin
         map_en  = 1'b1;
         cp      = {5'h00, seq_bytes_ff[11:8], seq_bytes_ff[5:0], b[5:0]};
         raw     = {8'h00, seq_bytes_ff[15:0], b};
         raw_len = 3'd3;
      end else begin
         map_en  = 1'b1;
         cp      = {seq_bytes_ff[18:16], seq_bytes_ff[13:8], seq_bytes_ff[5:0], b[5:0]};
         raw     = {seq_bytes_ff, b};
         raw_len = 3'd4;
      end
   end

   // code point mapping
   always_comb begin
      logic [7:0] c;
      logic       digit, alpha;
      c     = cp[7:0];
      digit = (c >= 8'h30 && c <= 8'h39);
      alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);

      kind       = KIND_NONE;
      emit_bytes = '0;
      emit_len   = 3'd1;

      if (!map_en) begin
         kind = KIND_NONE;
      end else if (cp <= CP_ASCII_MAX) begin
         if (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D)) begin
            kind = KIND_SPACE;
         end else if (digit || alpha) begin
            kind          = KIND_EMIT;
            emit_bytes[0] = lower_ascii(c);
         end else if (c == CH_APOS) begin
            kind = KIND_QUOTE;
         end else if (c == CH_HYPHEN) begin
            kind          = KIND_EMIT;
            emit_bytes[0] = CH_HYPHEN;
         end
      end else if (cp == CP_NBSP) begin
         kind = KIND_SPACE;
      end else if (cp == CP_LSQUO || cp == CP_RSQUO || cp == CP_SBQUO ||
                   cp == CP_LDQUO || cp == CP_RDQUO) begin
         kind = KIND_QUOTE;
      end else if (cp == CP_ENDASH || cp == CP_EMDASH) begin
         kind          = KIND_EMIT;
         emit_bytes[0] = CH_HYPHEN;
      end else if (cp >= CP_FW_FIRST && cp <= CP_FW_LAST) begin
         kind          = KIND_EMIT;
         emit_bytes[0] = lower_ascii(c + FW_OFFSET);
      end else begin
         kind       = KIND_EMIT;
         emit_bytes = raw;
         emit_len   = raw_len;
      end
   end

   // beat list: pre-space, up to four mapped bytes, flush space, up to three flush bytes
   always_comb begin
      logic [NUM_SLOTS-1:0]      slot_en;
      logic [NUM_SLOTS-1:0][7:0] slot_val;
      logic [3:0]                pos;
      logic [2:0]                idx;
      logic                      pend_map;
      logic                      flag_map;
      logic                      flush;

      pend_map = space_pending_ff;
      flag_map = last_space_ff;
      unique case (kind)
         KIND_SPACE: begin
            if (!last_space_ff) pend_map = 1'b1;
            flag_map = 1'b1;
         end
         KIND_EMIT: begin
            pend_map = 1'b0;
            flag_map = 1'b0;
         end
         KIND_QUOTE: flag_map = 1'b0;
         default: ;
      endcase

      slot_en  = '0;
      slot_val = '0;
      slot_en[0]  = space_pending_ff &&
                    ((kind == KIND_SPACE && !last_space_ff) || kind == KIND_EMIT);
      slot_val[0] = CH_SPACE;
      for (int i = 0; i < 4; i++) begin
         idx             = emit_len - 3'd1 - 3'(i);
         slot_en[1+i]    = (kind == KIND_EMIT) && (3'(i) < emit_len);
         slot_val[1+i]   = emit_bytes[idx[1:0]];
      end

      // open three- or four-byte sequence at end of string goes out raw
      flush       = fin && (seq_expected_step >= 3'd3);
      slot_en[5]  = flush && pend_map;
      slot_val[5] = CH_SPACE;
      for (int i = 0; i < 3; i++) begin
         idx           = {1'b0, seq_count_step} - 3'd1 - 3'(i);
         slot_en[6+i]  = flush && (2'(i) < seq_count_step);
         slot_val[6+i] = seq_bytes_step[8*idx[1:0] +: 8];
      end

      push_data = '0;
      pos       = 4'd0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (slot_en[i] && pos < 4'(MAX_RES)) begin
            push_data.bytes[pos[2:0]] = slot_val[i];
            pos = pos + 4'd1;
         end
      end
      push_data.count   = COUNT_W'(pos);
      push_data.present = 1'b1;
      push_data.last    = fin;
      if (pos == 4'd0) begin
         push_data.count   = COUNT_W'(1);
         push_data.present = 1'b0;
      end
      push_valid = req_tvalid && (pos != 4'd0 || fin);

      if (fin) begin
         seq_bytes_in     = '0;
         seq_expected_in  = 3'd0;
         seq_count_in     = 2'd0;
         last_space_in    = 1'b0;
         space_pending_in = 1'b0;
      end else begin
         seq_bytes_in     = seq_bytes_step;
         seq_expected_in  = seq_expected_step;
         seq_count_in     = seq_count_step;
         last_space_in    = flag_map;
         space_pending_in = pend_map;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_bytes_ff     <= '0;
         seq_expected_ff  <= 3'd0;
         seq_count_ff     <= 2'd0;
         last_space_ff    <= 1'b0;
         space_pending_ff <= 1'b0;
      end else if (accept) begin
         seq_bytes_ff     <= seq_bytes_in;
         seq_expected_ff  <= seq_expected_in;
         seq_count_ff     <= seq_count_in;
         last_space_ff    <= last_space_in;
         space_pending_ff <= space_pending_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/utn_queue.sv
// Short entry queue between front and back end.
// Register-based FIFO of utn_pkg::entry_type; DEPTH of 2 or more.
`default_nettype none
module utn_queue #(
   parameter int DEPTH = utn_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output logic                    push_ready,
   input  wire utn_pkg::entry_type push_data,
   output logic                    pop_valid,
   input  wire logic               pop_ready,
   output utn_pkg::entry_type      pop_data
);
   import utn_pkg::*;

   localparam int PTR_W  = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   entry_type          entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               do_push, do_pop;

   assign push_ready = (fill_ff != FILL_W'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      fill_in = fill_ff + FILL_W'(do_push) - FILL_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

FILE: src/utn_back.sv
// Back end: walks the beats of the head queue entry onto the result stream.
// Uses utn_pkg::entry_type.
`default_nettype none
module utn_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               pop_valid,
   output logic                    pop_ready,
   input  wire utn_pkg::entry_type pop_data,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [7:0]              rsp_tdata,   // [7:0] out_char
   output logic                    rsp_tuser,   // out_present
   output logic                    rsp_tlast    // out_end
);
   import utn_pkg::*;

   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic               final_beat;
   logic               beat_done;

   assign final_beat = (idx_ff == pop_data.count - COUNT_W'(1));
   assign beat_done  = rsp_tvalid && rsp_tready;

   assign rsp_tvalid = pop_valid;
   assign rsp_tdata  = pop_data.bytes[idx_ff];
   assign rsp_tuser  = pop_data.present;
   assign rsp_tlast  = pop_data.last && final_beat;
   assign pop_ready  = rsp_tready && final_beat;

   always_comb begin
      idx_in = idx_ff;
      if (beat_done) idx_in = final_beat ? '0 : idx_ff + COUNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/utf8_text_normalizer.sv
// Top level of the UTF-8 text normalizer: front end, entry queue, back end.
// Depends on utn_pkg, utn_front, utn_queue and utn_back.
//
// Usage: string bytes enter on the req_ stream, one byte per beat, req_tlast on
// the last byte of a string. Normalized bytes leave on the rsp_ stream;
// rsp_tuser is 1 when the beat carries a byte and 0 on a bare end marker,
// rsp_tlast marks the last beat of the string.
// An input byte is decoded and mapped in the cycle it is taken; its beats (one
// to five, or a bare end marker on the last byte) are queued as one entry in
// the registered queue and leave it one beat per cycle while rsp_tready is high.
// Throughput is one input byte per cycle while each byte yields at most one
// beat and rsp_tready is high; a byte yielding several beats holds the output
// until all of them have gone, and the QUEUE_DEPTH-entry queue absorbs such
// bursts. req_tready drops only when the queue is full.
// Reset clears the open sequence, the space state and the queue; no clearing
// pass is needed. While the receiver stalls, the head beat holds and input
// keeps flowing until the queue fills.
`default_nettype none
module utf8_text_normalizer #(
   parameter int QUEUE_DEPTH = utn_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   input  wire logic       req_tlast,   // in_final
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_char
   output logic            rsp_tuser,   // out_present
   output logic            rsp_tlast    // out_end
);
   import utn_pkg::*;

   logic      push_valid, push_ready;
   entry_type push_data;
   logic      pop_valid, pop_ready;
   entry_type pop_data;

   utn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   utn_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   utn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // a bare marker is always the closing beat and carries a zero byte
   a_marker_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tlast && rsp_tdata == 8'h00))
      else $error("bare end marker without tlast or with nonzero data");

   // input backpressure only when queued beats are waiting
   a_stall_has_output: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with nothing to deliver");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("block not empty after reset");

endmodule
`default_nettype wire
